@@ design/ots_pkg.sv @@
// ----------------------------------------------------------------------------
// Oscillator trim search package
// Shared widths, reset value, item kind codes and the search flag group.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ots_pkg;

    localparam int TRIM_WIDTH_DEF  = 9;
    localparam int COUNT_WIDTH_DEF = 20;

    // Reset value of the target count register
    localparam int unsigned IDEAL_RESET = 716;

    // Item kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_MEAS  = 1'b1;

    typedef struct packed {
        logic was_above;
        logic was_below;
        logic finished;
    } t_flags;

endpackage

@@ design/ots_cfg_if.sv @@
// ----------------------------------------------------------------------------
// Oscillator trim search configuration channel
// Valid/ready write channel carrying the target count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ots_cfg_if #(
    parameter int COUNT_WIDTH = ots_pkg::COUNT_WIDTH_DEF
);
    logic                   valid;
    logic                   ready;
    logic [COUNT_WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/ots_in_if.sv @@
// ----------------------------------------------------------------------------
// Oscillator trim search input channel
// Valid/ready channel carrying start and measurement items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ots_in_if #(
    parameter int TRIM_WIDTH  = ots_pkg::TRIM_WIDTH_DEF,
    parameter int COUNT_WIDTH = ots_pkg::COUNT_WIDTH_DEF
);
    logic                   valid;
    logic                   ready;
    logic                   kind;
    logic [TRIM_WIDTH-1:0]  start_trim;
    logic [COUNT_WIDTH-1:0] up_count;

    modport source (output valid, output kind, output start_trim, output up_count,
                    input ready);
    modport sink   (input valid, input kind, input start_trim, input up_count,
                    output ready);
endinterface

@@ design/ots_out_if.sv @@
// ----------------------------------------------------------------------------
// Oscillator trim search result channel
// Valid/ready channel carrying the trim decision for each item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ots_out_if #(
    parameter int TRIM_WIDTH = ots_pkg::TRIM_WIDTH_DEF
);
    logic                  valid;
    logic                  ready;
    logic [TRIM_WIDTH-1:0] trim_value;
    logic                  apply_trim;
    logic                  done_res;
    logic                  run_again;

    modport source (output valid, output trim_value, output apply_trim,
                    output done_res, output run_again, input ready);
    modport sink   (input valid, input trim_value, input apply_trim,
                    input done_res, input run_again, output ready);
endinterface

@@ design/ots_step.sv @@
// ----------------------------------------------------------------------------
// Oscillator trim search step
// Next search state and result for one registered item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ots_step #(
    parameter int TRIM_WIDTH  = ots_pkg::TRIM_WIDTH_DEF,
    parameter int COUNT_WIDTH = ots_pkg::COUNT_WIDTH_DEF
) (
    input  logic                   i_kind,
    input  logic [TRIM_WIDTH-1:0]  i_start_trim,
    input  logic [COUNT_WIDTH-1:0] i_up_count,
    input  logic [COUNT_WIDTH-1:0] i_ideal,
    input  logic [TRIM_WIDTH-1:0]  i_trim,
    input  logic [TRIM_WIDTH-1:0]  i_prev_trim,
    input  logic [COUNT_WIDTH-1:0] i_prev_count,
    input  ots_pkg::t_flags        i_flags,
    output logic [TRIM_WIDTH-1:0]  o_trim,
    output logic [TRIM_WIDTH-1:0]  o_prev_trim,
    output logic [COUNT_WIDTH-1:0] o_prev_count,
    output ots_pkg::t_flags        o_flags,
    output logic                   o_apply,
    output logic                   o_done,
    output logic                   o_again
);

    logic [COUNT_WIDTH-1:0] w_err_low;
    logic [COUNT_WIDTH-1:0] w_err_high;
    logic [COUNT_WIDTH-1:0] w_prev_err_high;
    logic [COUNT_WIDTH-1:0] w_prev_err_low;
    logic                   w_low;
    logic                   w_high;

    assign w_err_low       = i_ideal - i_up_count;
    assign w_err_high      = i_up_count - i_ideal;
    assign w_prev_err_high = i_prev_count - i_ideal;
    assign w_prev_err_low  = i_ideal - i_prev_count;
    assign w_low           = i_up_count < i_ideal;
    assign w_high          = i_up_count > i_ideal;

    always_comb begin
        o_trim       = i_trim;
        o_prev_trim  = i_prev_trim;
        o_prev_count = i_prev_count;
        o_flags      = i_flags;
        o_apply      = 1'b0;
        o_again      = 1'b0;
        if (i_kind == ots_pkg::KIND_START) begin
            o_trim  = i_start_trim;
            o_flags = '0;
            o_again = 1'b1;
        end else if (!i_flags.finished) begin
            priority if (w_low) begin
                if (i_flags.was_above) begin
                    // crossed from above: keep the closer of the last two trims
                    if (w_err_low > w_prev_err_high) begin
                        o_trim = i_prev_trim;
                    end
                    o_flags.finished = 1'b1;
                end else if (w_err_low == COUNT_WIDTH'(1)) begin
                    o_flags.finished = 1'b1;
                end else begin
                    o_prev_trim  = i_trim;
                    o_prev_count = i_up_count;
                    o_flags.was_below = 1'b1;
                    if (i_trim != '0) begin
                        o_trim = i_trim - TRIM_WIDTH'(1);
                    end
                end
            end else if (w_high) begin
                if (i_flags.was_below) begin
                    if (w_err_high > w_prev_err_low) begin
                        o_trim = i_prev_trim;
                    end
                    o_flags.finished = 1'b1;
                end else if (w_err_high == COUNT_WIDTH'(1)) begin
                    o_flags.finished = 1'b1;
                end else begin
                    o_prev_trim  = i_trim;
                    o_prev_count = i_up_count;
                    o_flags.was_above = 1'b1;
                    if (i_trim != '1) begin
                        o_trim = i_trim + TRIM_WIDTH'(1);
                    end
                end
            end else begin
                o_flags.finished = 1'b1;
            end
            o_apply = w_low || w_high;
            o_again = !o_flags.finished;
        end
    end

    assign o_done = o_flags.finished;

endmodule

@@ design/oscillator_trim_search.sv @@
// ----------------------------------------------------------------------------
// Oscillator trim search
// Path: an input beat passes the input register, then the result register;
//   the search state updates with the result register.
// Throughput: one item per cycle while the result side accepts each beat.
// Reset: synchronous active low; clears trim state, flags and both valid bits,
//   and loads the target count with its default.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module oscillator_trim_search #(
    parameter int TRIM_WIDTH  = ots_pkg::TRIM_WIDTH_DEF,
    parameter int COUNT_WIDTH = ots_pkg::COUNT_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ots_cfg_if.sink   i_cfg,
    ots_in_if.sink    i_in,
    ots_out_if.source o_out
);

    logic                   r_in_valid;
    logic                   r_in_kind;
    logic [TRIM_WIDTH-1:0]  r_in_start_trim;
    logic [COUNT_WIDTH-1:0] r_in_up_count;

    logic [COUNT_WIDTH-1:0] r_ideal;
    logic [TRIM_WIDTH-1:0]  r_trim;
    logic [TRIM_WIDTH-1:0]  r_prev_trim;
    logic [COUNT_WIDTH-1:0] r_prev_count;
    ots_pkg::t_flags        r_flags;

    logic                   r_out_valid;
    logic [TRIM_WIDTH-1:0]  r_out_trim;
    logic                   r_out_apply;
    logic                   r_out_done;
    logic                   r_out_again;

    logic [TRIM_WIDTH-1:0]  n_trim;
    logic [TRIM_WIDTH-1:0]  n_prev_trim;
    logic [COUNT_WIDTH-1:0] n_prev_count;
    ots_pkg::t_flags        n_flags;
    logic                   n_apply;
    logic                   n_done;
    logic                   n_again;

    logic                   w_advance;
    logic                   w_in_ready;

    // advance the held beat whenever the result slot is free or draining
    assign w_advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign w_in_ready = !r_in_valid || w_advance;
    assign i_in.ready = w_in_ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ideal <= COUNT_WIDTH'(ots_pkg::IDEAL_RESET);
        end else if (i_cfg.valid) begin
            r_ideal <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_in.valid) begin
            r_in_kind       <= i_in.kind;
            r_in_start_trim <= i_in.start_trim;
            r_in_up_count   <= i_in.up_count;
        end
    end

    ots_step #(
        .TRIM_WIDTH  (TRIM_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .i_kind       (r_in_kind),
        .i_start_trim (r_in_start_trim),
        .i_up_count   (r_in_up_count),
        .i_ideal      (r_ideal),
        .i_trim       (r_trim),
        .i_prev_trim  (r_prev_trim),
        .i_prev_count (r_prev_count),
        .i_flags      (r_flags),
        .o_trim       (n_trim),
        .o_prev_trim  (n_prev_trim),
        .o_prev_count (n_prev_count),
        .o_flags      (n_flags),
        .o_apply      (n_apply),
        .o_done       (n_done),
        .o_again      (n_again)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trim       <= '0;
            r_prev_trim  <= '0;
            r_prev_count <= '0;
            r_flags      <= '0;
        end else if (w_advance) begin
            r_trim       <= n_trim;
            r_prev_trim  <= n_prev_trim;
            r_prev_count <= n_prev_count;
            r_flags      <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_trim  <= n_trim;
            r_out_apply <= n_apply;
            r_out_done  <= n_done;
            r_out_again <= n_again;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.trim_value = r_out_trim;
    assign o_out.apply_trim = r_out_apply;
    assign o_out.done_res   = r_out_done;
    assign o_out.run_again  = r_out_again;

`ifndef SYNTHESIS
    // the done flag drops only on a start beat
    a_done_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_flags.finished) |-> $past(w_advance && r_in_kind == ots_pkg::KIND_START))
        else $error("search flag cleared without a start item");

    // measurements after done leave the trim alone
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_kind == ots_pkg::KIND_MEAS && r_flags.finished)
        |=> $stable(r_trim))
        else $error("trim changed after search finished");

    a_done_again: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_done && r_out_again))
        else $error("result asks for another run after finishing");

    // an empty result slot never blocks the input
    a_in_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> w_in_ready)
        else $error("input stalled with empty result register");
`endif

endmodule

@@ tb/sv/ots_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// Oscillator trim search checker package
// Decision record and a scoreboard that predicts the trim decision for each
// accepted item and compares it with each result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ots_tb_pkg;

    import ots_pkg::*;

    localparam int TW = TRIM_WIDTH_DEF;
    localparam int CW = COUNT_WIDTH_DEF;

    typedef struct packed {
        logic [TW-1:0] trim_value;
        logic          apply_trim;
        logic          done_res;
        logic          run_again;
    } t_decision;

    class trim_decision_board;
        logic [CW-1:0] target;
        logic [TW-1:0] trim;
        logic [TW-1:0] prev_trim;
        logic [CW-1:0] prev_count;
        t_flags        flags;
        t_decision     expected_decisions[$];
        int unsigned   failures;
        int unsigned   checked;

        function new();
            target     = CW'(IDEAL_RESET);
            trim       = '0;
            prev_trim  = '0;
            prev_count = '0;
            flags      = '0;
            failures   = 0;
            checked    = 0;
        endfunction

        function void set_target(input logic [CW-1:0] value);
            target = value;
        endfunction

        function int pending();
            return expected_decisions.size();
        endfunction

        // Advance the search state by one accepted item and queue its decision
        function void predict_item(input logic kind, input logic [TW-1:0] start_trim,
                                   input logic [CW-1:0] up_count);
            t_decision     d;
            logic [CW-1:0] miss;
            logic [CW-1:0] last_miss;
            d.apply_trim = 1'b0;
            d.run_again  = 1'b0;
            if (kind == KIND_START) begin
                trim        = start_trim;
                flags       = '0;
                d.run_again = 1'b1;
            end else if (!flags.finished) begin
                if (up_count < target) begin
                    miss      = target - up_count;
                    last_miss = prev_count - target;
                    if (flags.was_above) begin
                        // crossed from above: keep the closer of the last two trims
                        if (miss > last_miss)
                            trim = prev_trim;
                        flags.finished = 1'b1;
                    end else if (miss == CW'(1)) begin
                        flags.finished = 1'b1;
                    end else begin
                        prev_trim = trim;
                        if (trim != '0)
                            trim = trim - 1'b1;
                        flags.was_below = 1'b1;
                        prev_count      = up_count;
                    end
                end else if (up_count > target) begin
                    miss      = up_count - target;
                    last_miss = target - prev_count;
                    if (flags.was_below) begin
                        if (miss > last_miss)
                            trim = prev_trim;
                        flags.finished = 1'b1;
                    end else if (miss == CW'(1)) begin
                        flags.finished = 1'b1;
                    end else begin
                        prev_trim = trim;
                        if (trim != '1)
                            trim = trim + 1'b1;
                        flags.was_above = 1'b1;
                        prev_count      = up_count;
                    end
                end else begin
                    flags.finished = 1'b1;
                end
                d.apply_trim = (up_count != target);
                d.run_again  = !flags.finished;
            end
            d.trim_value = trim;
            d.done_res   = flags.finished;
            expected_decisions.push_back(d);
        endfunction

        function void check_decision(input logic [TW-1:0] trim_value, input logic apply_trim,
                                     input logic done_res, input logic run_again);
            t_decision want;
            if (expected_decisions.size() == 0) begin
                $error("result beat with no expectation: trim_value %0d", trim_value);
                failures++;
                return;
            end
            want = expected_decisions.pop_front();
            checked++;
            if (trim_value !== want.trim_value) begin
                $error("trim_value: expected %0d, actual %0d", want.trim_value, trim_value);
                failures++;
            end
            if (apply_trim !== want.apply_trim) begin
                $error("apply_trim: expected %0d, actual %0d", want.apply_trim, apply_trim);
                failures++;
            end
            if (done_res !== want.done_res) begin
                $error("done_res: expected %0d, actual %0d", want.done_res, done_res);
                failures++;
            end
            if (run_again !== want.run_again) begin
                $error("run_again: expected %0d, actual %0d", want.run_again, run_again);
                failures++;
            end
        endfunction
    endclass

endpackage

@@ tb/sv/oscillator_trim_search_tb.sv @@
// ----------------------------------------------------------------------------
// Oscillator trim search testbench
// Drives start and measurement items, mostly as converging searches against
// a simple oscillator model, under several target counts and stall patterns,
// and checks every result beat against the scoreboard's prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module oscillator_trim_search_tb;

    import ots_pkg::*;
    import ots_tb_pkg::*;

    localparam int          CMAX        = (1 << CW) - 1;
    localparam int          HOLD_CYCLES = 300;
    localparam int          SETTLE      = 6;
    localparam int          SUB_ITEMS   = 100;
    localparam longint      LIMIT_NS    = 4000000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ots_cfg_if cfg_if ();
    ots_in_if  in_if ();
    ots_out_if out_if ();

    oscillator_trim_search uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    trim_decision_board sb;

    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int hold_requests = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int items_sent    = 0;
    int targets_set   = 0;

    always #4 i_clk = ~i_clk;

    // Result side: check accepted beats, then choose ready for the next edge
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check_decision(out_if.trim_value, out_if.apply_trim, out_if.done_res,
                              out_if.run_again);
        if (hold_requests != hold_seen) begin
            hold_seen    <= hold_requests;
            hold_left    <= HOLD_CYCLES;
            out_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_item(input logic kind, input logic [TW-1:0] start_trim,
                             input logic [CW-1:0] up_count);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.kind       <= kind;
        in_if.start_trim <= start_trim;
        in_if.up_count   <= up_count;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        sb.predict_item(kind, start_trim, up_count);
        items_sent++;
    endtask

    // Drop valid and wait until every result beat has come back
    task automatic settle_block();
        in_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_target(input logic [CW-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        @(posedge i_clk);
        while (!cfg_if.ready)
            @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        sb.set_target(value);
        targets_set++;
    endtask

    // One search against a linear oscillator: count falls as the trim rises
    task automatic run_search(input int budget, output int used);
        int            hidden;
        int            slope;
        int            count;
        int            jitter;
        int            steps;
        logic [TW-1:0] st;
        used = 0;
        st   = TW'($urandom);
        if ($urandom_range(7) == 0)
            hidden = int'($urandom_range(CMAX >> (CW - TW)));
        else
            hidden = int'(st) + int'($urandom_range(30)) - 15;
        slope = int'($urandom_range(40, 1));
        // now and then continue the previous search instead of starting anew
        if ($urandom_range(9) != 0) begin
            send_item(KIND_START, st, CW'($urandom));
            used++;
        end
        steps = 0;
        while (!sb.flags.finished && steps < 40 && used < budget) begin
            jitter = ($urandom_range(3) == 0) ? int'($urandom_range(4)) - 2 : 0;
            count  = int'(sb.target) + (hidden - int'(sb.trim)) * slope + jitter;
            if (count < 0)
                count = 0;
            if (count > CMAX)
                count = CMAX;
            send_item(KIND_MEAS, TW'($urandom), CW'(count));
            used++;
            steps++;
        end
        if (sb.flags.finished && used < budget && $urandom_range(1) == 1) begin
            send_item(KIND_MEAS, TW'($urandom), CW'($urandom));
            used++;
        end
    endtask

    initial begin
        #(LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int            used;
        int            done_items;
        logic [CW-1:0] tgt;
        sb = new();
        i_rst_n          <= 1'b0;
        cfg_if.valid     <= 1'b0;
        cfg_if.data      <= '0;
        in_if.valid      <= 1'b0;
        in_if.kind       <= KIND_START;
        in_if.start_trim <= '0;
        in_if.up_count   <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, first on the reset target
        tx_idle_pct = 29;
        rx_idle_pct = 83;
        send_item(KIND_MEAS, '0, CW'(700));     // search from reset state, floor at 0
        send_item(KIND_MEAS, '0, CW'(800));     // cross from below, keep older trim
        send_item(KIND_MEAS, '1, '0);           // after done
        send_item(KIND_START, '1, '1);
        send_item(KIND_MEAS, '0, CW'(1000));    // ceiling at the largest trim
        send_item(KIND_MEAS, '0, CW'(717));     // miss of one above
        send_item(KIND_START, TW'(9'h155), '0);
        send_item(KIND_MEAS, '0, CW'(716));     // exact hit
        send_item(KIND_START, TW'(9'h0aa), '0);
        send_item(KIND_MEAS, '0, CW'(600));
        send_item(KIND_MEAS, '0, CW'(650));
        send_item(KIND_MEAS, '0, CW'(715));     // miss of one below
        send_item(KIND_START, TW'(256), CW'(20'haaaaa));
        send_item(KIND_MEAS, '0, CW'(900));
        send_item(KIND_MEAS, '0, CW'(500));     // cross from above
        settle_block();
        write_target('1);
        send_item(KIND_START, '1, '0);
        send_item(KIND_MEAS, '0, '1);
        send_item(KIND_START, TW'(3), '0);
        send_item(KIND_MEAS, '0, '0);
        settle_block();
        // change the target in the middle of a search
        write_target('0);
        send_item(KIND_MEAS, TW'(9'h155), '1);
        settle_block();
        write_target(CW'(1));
        send_item(KIND_START, '0, '0);
        send_item(KIND_MEAS, '0, '0);
        send_item(KIND_START, TW'(7), '0);
        send_item(KIND_MEAS, '0, CW'(2));

        for (int phase = 0; phase < 3; phase++) begin
            for (int sub = 0; sub < 5; sub++) begin
                settle_block();
                case ($urandom_range(5))
                    0: tgt = '0;
                    1: tgt = '1;
                    2: tgt = CW'(IDEAL_RESET);
                    3: tgt = CW'(1);
                    4: tgt = CW'($urandom_range(4095));
                    default: tgt = CW'($urandom);
                endcase
                write_target(tgt);
                case (phase)
                    0: begin
                        tx_idle_pct = 29;
                        rx_idle_pct = 83;
                    end
                    1: begin
                        tx_idle_pct = 83;
                        rx_idle_pct = 29;
                    end
                    default: begin
                        tx_idle_pct = 0;
                        rx_idle_pct = 0;
                    end
                endcase
                // stall the result side long enough to back up the input
                if (phase == 2 && sub == 0)
                    hold_requests <= hold_requests + 1;
                done_items = 0;
                while (done_items < SUB_ITEMS) begin
                    if ($urandom_range(4) == 0) begin
                        if ($urandom_range(1) == 0)
                            send_item(logic'($urandom_range(1)), TW'($urandom),
                                      CW'($urandom));
                        else
                            send_item(KIND_MEAS, TW'($urandom),
                                      sb.target + CW'($urandom_range(4)) - CW'(2));
                        done_items++;
                    end else begin
                        run_search(SUB_ITEMS - done_items, used);
                        done_items += used;
                    end
                end
            end
        end
        settle_block();

        if (sb.pending() != 0) begin
            $error("%0d expected result beats never arrived", sb.pending());
            sb.failures++;
        end
        $display("Summary: %0d items over %0d target writes, %0d result beats checked",
                 items_sent, targets_set, sb.checked);
        $display("Summary: searches from both trim limits, crossings, near misses, stalls");
        if (sb.failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ files.f @@
design/ots_pkg.sv
design/ots_cfg_if.sv
design/ots_in_if.sv
design/ots_out_if.sv
design/ots_step.sv
design/oscillator_trim_search.sv
tb/sv/ots_tb_pkg.sv
tb/sv/oscillator_trim_search_tb.sv
